>>> src/swst_pkg.sv
// Shared item types and constants for the sliding window statistics block.
package swst_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_W     = 7;
    localparam int CNT_OUT_W = 7;

    localparam logic        KIND_ADD   = 1'b0;
    localparam logic        KIND_CLEAR = 1'b1;

    localparam logic signed [DATA_W-1:0] LOW_CAP    = 16'sd1000;
    localparam logic signed [DATA_W-1:0] HIGH_FLOOR = 16'sd0;
    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -16'sd1;
    localparam logic        [CFG_W-1:0]  WINDOW_LENGTH_RESET = 7'd16;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] sample;
    } swst_item_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0]     count;
        logic signed [DATA_W-1:0] latest;
        logic signed [DATA_W-1:0] oldest;
        logic signed [DATA_W-1:0] lowest;
        logic signed [DATA_W-1:0] highest;
        logic signed [DATA_W-1:0] mean;
    } swst_result_t;

endpackage

>>> src/swst_front.sv
// Front end: accepts items, tidies clear items and holds them in a two-entry queue.
module swst_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  swst_pkg::swst_item_t in_item,
    output logic               q_valid,
    input  logic               q_take,
    output swst_pkg::swst_item_t q_item
);
    import swst_pkg::*;

    swst_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic [1:0] level_next;
    logic       push;
    logic       pop;
    swst_item_t tidy_item;

    assign in_stall = (level_reg == 2'd2);
    assign q_valid  = (level_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_valid && q_take;

    // A clear item carries no sample: drop it here.
    always_comb
    begin
        tidy_item = in_item;
        if (in_item.kind == KIND_CLEAR)
        begin
            tidy_item.sample = '0;
        end
    end

    always_comb
    begin
        level_next = level_reg;
        case ({push, pop})
            2'b10:   level_next = level_reg + 2'd1;
            2'b01:   level_next = level_reg - 2'd1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= tidy_item;
        end
    end

endmodule

>>> src/swst_div.sv
// Signed by unsigned restoring divider, one quotient bit per cycle, truncating toward zero.
module swst_div #(
    parameter int SUM_W = 23,
    parameter int CNT_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [CNT_W-1:0] divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);
    import swst_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_next;
    logic              quo_bit;
    logic [SUM_W-1:0]  magnitude;

    assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};

    always_comb
    begin
        quo_bit  = 1'b0;
        rem_next = rem_shift;
        if (rem_shift >= {1'b0, dsr_reg})
        begin
            quo_bit  = 1'b1;
            rem_next = rem_shift - {1'b0, dsr_reg};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], quo_bit};
            rem_reg <= rem_next;
        end
    end

endmodule

>>> src/swst_back.sv
// Back end: sample ring, window update, scan for min/max/sum, divide and result register.
module swst_back #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [swst_pkg::CFG_W-1:0] window_length,
    input  logic                       q_valid,
    output logic                       q_take,
    input  swst_pkg::swst_item_t       q_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output swst_pkg::swst_result_t     out_item
);
    import swst_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W = DATA_W + CNT_W;
    localparam logic [CNT_W:0] RING_SIZE = (CNT_W + 1)'(MAX_WINDOW);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_TRIM  = 8'b00000010,
        S_WRITE = 8'b00000100,
        S_SCAN  = 8'b00001000,
        S_DIVGO = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_DONE  = 8'b01000000,
        S_SPARE = 8'b10000000
    } swst_state_t;

    swst_state_t              state_reg;
    swst_state_t              state_next;
    logic [IDX_W-1:0]         head_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         iss_reg;
    logic [CNT_W-1:0]         rcv_reg;
    logic                     rd_vld_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    swst_item_t               item_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [DATA_W-1:0] hi_reg;
    logic signed [DATA_W-1:0] oldest_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     out_valid_reg;
    swst_result_t             out_reg;
    logic signed [DATA_W-1:0] ring_mem [MAX_WINDOW];

    logic [LEN_W-1:0]         len_wide;
    logic [CNT_W-1:0]         eff_len;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         wr_addr;
    logic                     slot_free;
    logic                     div_done;
    logic signed [SUM_W-1:0]  div_quo;
    swst_result_t             result;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] total;
        total = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
        if (total >= RING_SIZE)
        begin
            total = total - RING_SIZE;
        end
        return total[IDX_W-1:0];
    endfunction

    // A length of zero acts as one; saturate at the ring size.
    always_comb
    begin
        len_wide = LEN_W'(window_length);
        if (len_wide == '0)
        begin
            len_wide = LEN_W'(1);
        end
        else if (len_wide > LEN_W'(MAX_WINDOW))
        begin
            len_wide = LEN_W'(MAX_WINDOW);
        end
        eff_len = CNT_W'(len_wide);
    end

    assign q_take    = (state_reg == S_IDLE);
    assign rd_en     = (state_reg == S_SCAN) && (iss_reg < fill_reg);
    assign rd_addr   = ring_add(head_reg, iss_reg);
    assign wr_addr   = ring_add(head_reg, fill_reg);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        if (fill_reg == '0)
        begin
            result.count   = '0;
            result.latest  = '0;
            result.oldest  = '0;
            result.lowest  = EMPTY_MARK;
            result.highest = EMPTY_MARK;
            result.mean    = '0;
        end
        else
        begin
            result.count   = CNT_OUT_W'(fill_reg);
            result.latest  = item_reg.sample;
            result.oldest  = oldest_reg;
            result.lowest  = lo_reg;
            result.highest = hi_reg;
            result.mean    = mean_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_TRIM;
                end
            end
            S_TRIM:
            begin
                state_next = (item_reg.kind == KIND_CLEAR) ? S_DONE : S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_vld_reg && (rcv_reg + 1'b1 == fill_reg))
                begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            iss_reg       <= '0;
            rcv_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (rd_en)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            if (rd_vld_reg)
            begin
                rcv_reg <= rcv_reg + 1'b1;
            end
            if (state_reg == S_TRIM)
            begin
                if (item_reg.kind == KIND_CLEAR)
                begin
                    head_reg <= '0;
                    fill_reg <= '0;
                end
                else if (fill_reg >= eff_len)
                begin
                    // Evict down to one slot below the length.
                    head_reg <= ring_add(head_reg, fill_reg - eff_len + 1'b1);
                    fill_reg <= eff_len - 1'b1;
                end
            end
            if (state_reg == S_WRITE)
            begin
                fill_reg <= fill_reg + 1'b1;
                iss_reg  <= '0;
                rcv_reg  <= '0;
            end
            if ((state_reg == S_DONE) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take && q_valid)
        begin
            item_reg <= q_item;
        end
        if (state_reg == S_WRITE)
        begin
            ring_mem[wr_addr] <= item_reg.sample;
            lo_reg            <= LOW_CAP;
            hi_reg            <= HIGH_FLOOR;
            sum_reg           <= '0;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (rd_vld_reg)
        begin
            if (rcv_reg == '0)
            begin
                oldest_reg <= rd_data_reg;
            end
            if (rd_data_reg < lo_reg)
            begin
                lo_reg <= rd_data_reg;
            end
            if (rd_data_reg > hi_reg)
            begin
                hi_reg <= rd_data_reg;
            end
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
        end
        if (div_done)
        begin
            mean_reg <= div_quo[DATA_W-1:0];
        end
        if ((state_reg == S_DONE) && slot_free)
        begin
            out_reg <= result;
        end
    end

    swst_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DIVGO),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule

>>> src/sliding_window_statistics.sv
// Sliding window statistics: top level with length register, front queue and back end.
//
// Input channel in_valid/in_stall/in_item: an item is taken at a clock edge with in_valid
// high and in_stall low. kind ADD pushes a sample, evicting the oldest when the window is
// full; kind CLEAR empties the window. Every item gives one result on out_valid/out_stall/
// out_item: count, latest, oldest, lowest (capped at 1000), highest (floored at 0) and the
// mean truncated toward zero. An empty window reports -1 for lowest and highest, 0 else.
// cfg_write/cfg_data set the window length (0 acts as 1, above MAX_WINDOW saturates);
// write it only while no item is in flight. Reset sets the length to 16 and empties the
// window; the sample ring itself is not cleared.
// A two-entry queue takes items while the back end works. An add item makes one ring read
// per held sample, then one divider step per sum bit; a clear item skips both. The back
// end takes one item at a time; the ring read port and the serial divider set its pace.
// The result sits in an output register; while out_stall is high it holds and the back end
// finishes the next item and waits for the slot.
module sliding_window_statistics #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [swst_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  swst_pkg::swst_item_t       in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output swst_pkg::swst_result_t     out_item
);
    import swst_pkg::*;

    logic [CFG_W-1:0] window_length_reg;
    logic             q_valid;
    logic             q_take;
    swst_item_t       q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            window_length_reg <= cfg_data;
        end
    end

    swst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    swst_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .q_valid       (q_valid),
        .q_take        (q_take),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

    // An empty window reports the fixed marks.
    a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.count == '0)) |->
        ((out_item.lowest == EMPTY_MARK) && (out_item.highest == EMPTY_MARK) &&
         (out_item.mean == '0) && (out_item.latest == '0) && (out_item.oldest == '0)))
        else $error("empty window result has wrong marks");

    // The mean lies between the capped minimum and the floored maximum.
    a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.count != '0)) |->
        (($signed(out_item.lowest) <= $signed(out_item.mean)) &&
         ($signed(out_item.mean) <= $signed(out_item.highest)) &&
         ($signed(out_item.lowest) <= $signed(LOW_CAP)) &&
         ($signed(out_item.highest) >= $signed(HIGH_FLOOR))))
        else $error("window statistics out of order");

    // The reported count never exceeds the ring.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((MAX_WINDOW > 127) || (int'(out_item.count) <= MAX_WINDOW)))
        else $error("count exceeds ring size");

endmodule

>>> tb/sliding_window_statistics_tb.sv
// Self-checking testbench for the sliding window statistics block.
`timescale 1ns / 1ps

module sliding_window_statistics_tb;
    import swst_pkg::*;

    localparam int MAX_WINDOW  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    swst_item_t           in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    swst_result_t         out_item;

    // Own copy of the window and the length register
    logic signed [DATA_W-1:0] win_samples [MAX_WINDOW];
    int                       win_head = 0;
    int                       win_fill = 0;
    logic [CFG_W-1:0]         win_length = WINDOW_LENGTH_RESET;

    swst_item_t   pending_items [$];
    swst_result_t expected_stats [$];

    bit quiet = 1'b0;
    int gap_left = 0;
    int hold_left = 0;
    int errors = 0;
    int items_taken = 0;
    int clears_taken = 0;
    int results_checked = 0;
    int length_writes = 0;
    int cycle_count = 0;

    sliding_window_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_stats.size());
            $display("sliding_window_statistics_tb failed");
            $finish;
        end
    end

    // Update the window for one accepted item and queue the statistics it yields
    task automatic advance_window(input swst_item_t it);
        int                eff;
        int                lo;
        int                hi;
        int                total;
        int                v;
        int                i;
        swst_result_t      r;
        if (it.kind == KIND_CLEAR)
        begin
            win_head = 0;
            win_fill = 0;
        end
        else
        begin
            eff = int'(win_length);
            if (eff == 0)
                eff = 1;
            if (eff > MAX_WINDOW)
                eff = MAX_WINDOW;
            // evict oldest until one slot below the length is left
            while (win_fill >= eff)
            begin
                win_head = (win_head + 1) % MAX_WINDOW;
                win_fill--;
            end
            win_samples[(win_head + win_fill) % MAX_WINDOW] = it.sample;
            win_fill++;
        end
        if (win_fill == 0)
        begin
            r.count   = '0;
            r.latest  = '0;
            r.oldest  = '0;
            r.lowest  = EMPTY_MARK;
            r.highest = EMPTY_MARK;
            r.mean    = '0;
        end
        else
        begin
            lo = LOW_CAP;
            hi = HIGH_FLOOR;
            total = 0;
            for (i = 0; i < win_fill; i++)
            begin
                v = win_samples[(win_head + i) % MAX_WINDOW];
                if (v < lo)
                    lo = v;
                if (v > hi)
                    hi = v;
                total += v;
            end
            r.count   = win_fill[CNT_OUT_W-1:0];
            r.latest  = win_samples[(win_head + win_fill - 1) % MAX_WINDOW];
            r.oldest  = win_samples[win_head];
            r.lowest  = lo[DATA_W-1:0];
            r.highest = hi[DATA_W-1:0];
            r.mean    = DATA_W'(total / win_fill);
        end
        expected_stats.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, seen);
            errors++;
        end
    endtask

    task automatic check_result(input swst_result_t got);
        swst_result_t want;
        if (expected_stats.size() == 0)
        begin
            $display("%0t: unexpected result: count %0d latest %0d mean %0d",
                     $time, got.count, got.latest, got.mean);
            errors++;
        end
        else
        begin
            want = expected_stats.pop_front();
            results_checked++;
            compare_field("count", want.count, got.count);
            compare_field("latest", want.latest, got.latest);
            compare_field("oldest", want.oldest, got.oldest);
            compare_field("lowest", want.lowest, got.lowest);
            compare_field("highest", want.highest, got.highest);
            compare_field("mean", want.mean, got.mean);
        end
    endtask

    // Driver: hold a stalled item, otherwise advance to the next one after its gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_window(in_item);
                items_taken++;
                if (in_item.kind == KIND_CLEAR)
                    clears_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    gap_left = quiet ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall for a drawn number of valid cycles before each result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result(out_item);
                hold_left = quiet ? 0 : $urandom_range(0, 7);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                if (out_valid)
                    hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return DATA_W'($urandom_range(0, 2) + 999);
            3: return DATA_W'(int'($urandom_range(0, 4)) - 2);
            4: return DATA_W'(int'($urandom_range(0, 4000)) - 2000);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic queue_add(input logic signed [DATA_W-1:0] value);
        swst_item_t it;
        it.kind = KIND_ADD;
        it.sample = value;
        pending_items.push_back(it);
    endtask

    task automatic queue_clear(input logic [DATA_W-1:0] junk);
        swst_item_t it;
        it.kind = KIND_CLEAR;
        it.sample = junk;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_stats.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= len;
        win_length = len;
        length_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int lengths [$];
        int p;
        int n;
        lengths = '{127, 64, 65, 1, 0, 2, 3, 8, 16, 31, 48, 63, 100, 5};
        lengths.push_back($urandom_range(0, 127));
        lengths.push_back($urandom_range(0, 127));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty window, field extremes, the cap and floor, mean truncation
        queue_clear(16'hffff);
        queue_add(16'sh8000);
        queue_add(16'sh7fff);
        queue_add(16'sd1000);
        queue_add(16'sd1001);
        queue_add(-16'sd1);
        queue_add(16'sd0);
        queue_clear(16'h5a5a);
        queue_add(16'sd500);
        queue_add(-16'sd7);
        queue_add(16'sd2);
        wait_idle();

        // Eviction on a full window, then a shrink trimmed by the next add
        write_length(7'd4);
        queue_add(16'sd10);
        queue_add(-16'sd20);
        wait_idle();
        write_length(7'd2);
        queue_add(16'sd77);
        wait_idle();
        write_length(7'd0);
        queue_add(16'sd5);
        queue_add(-16'sd5);
        wait_idle();
        write_length(7'd1);
        queue_add(16'sd3);
        queue_clear(16'h0000);
        wait_idle();

        // Random phases over a spread of lengths, some with no idling at all
        for (p = 0; p < lengths.size(); p++)
        begin
            write_length(lengths[p][CFG_W-1:0]);
            quiet = (p % 4 == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                    queue_clear(DATA_W'($urandom));
                else
                    queue_add(draw_sample());
            end
            wait_idle();
        end

        repeat (300) @(negedge clk);
        $display("Covered %0d items (%0d clears) over %0d window length writes;",
                 items_taken, clears_taken, length_writes);
        $display("%0d results checked, %0d mismatches.", results_checked, errors);
        if (errors == 0 && expected_stats.size() == 0)
            $display("sliding_window_statistics_tb passed");
        else
            $display("sliding_window_statistics_tb failed");
        $finish;
    end

endmodule
